[src/mte_pkg.sv]
// Types, constants and key character tables for the multi-tap text entry block.
package mte_pkg;

   typedef struct packed {
      logic       func;
      logic [3:0] key;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] character;
      logic [4:0] column;
      logic [1:0] row;
      logic       replace;
      logic [5:0] length;
   } rsp_type;

   localparam logic       FUNC_PRESS    = 1'b0;
   localparam logic       FUNC_TICK     = 1'b1;
   localparam logic       KIND_SHOW     = 1'b0;
   localparam logic       KIND_DONE     = 1'b1;
   localparam logic [3:0] KEY_AT        = 4'd10;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_AT       = 8'h40;
   localparam logic [1:0] ROW_LAST      = 2'd3;
   localparam logic [15:0] TIMEOUT_RESET = 16'd7814;
   localparam logic [15:0] TICK_MAX      = 16'hFFFF;

   function automatic logic [3:0] key_len(input logic [3:0] k);
      logic [3:0] n;
      case (k)
         4'd0:    n = 4'd1;
         4'd1:    n = 4'd4;
         4'd7:    n = 4'd9;
         4'd9:    n = 4'd9;
         4'd10:   n = 4'd1;
         default: n = 4'd7;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] key_char(input logic [3:0] k, input logic [3:0] idx);
      logic [71:0] lst;
      logic [3:0]  sel;
      lst = '0;
      case (k)
         4'd0:    lst = 72'("0");
         4'd1:    lst = 72'(".,?1");
         4'd2:    lst = 72'("abcABC2");
         4'd3:    lst = 72'("defDEF3");
         4'd4:    lst = 72'("ghiGHI4");
         4'd5:    lst = 72'("jklJKL5");
         4'd6:    lst = 72'("mnoMNO6");
         4'd7:    lst = 72'("pqrsPQRS7");
         4'd8:    lst = 72'("tuvTUV8");
         4'd9:    lst = 72'("wxyzWXYZ9");
         4'd10:   lst = 72'("@");
         default: lst = '0;
      endcase
      sel = key_len(k) - 4'd1 - idx;
      return lst[{sel, 3'b000} +: 8];
   endfunction

endpackage

[src/multitap_text_entry.sv]
// Multi-tap keypad text entry: cell, cursor and message state with a registered result.
// An accepted item's result is held in the result register in the next cycle.
// Throughput: one item per cycle; req_ready drops only while a held result is not taken.
// Each item is handled by one pass of logic from the state registers to the result register.
// Reset (synchronous, active high) closes the cell, homes the cursor to row 1 column 1,
// clears the count and sets the timeout to 7814 ticks.
module multitap_text_entry #(
   parameter int MAX_CHARS = 32,
   parameter int ROW_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mte_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mte_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);

   localparam int CNT_W = (MAX_CHARS < 2) ? 1 : $clog2(MAX_CHARS + 1);
   localparam int COL_W = $clog2(ROW_WIDTH + 1);

   logic [15:0]      timeout_ff;
   logic             cell_open_ff, cell_open_in;
   logic [3:0]       prev_key_ff, prev_key_in;
   logic [3:0]       tap_idx_ff, tap_idx_in;
   logic [15:0]      tick_cnt_ff, tick_cnt_in;
   logic             timed_out_ff, timed_out_in;
   logic [7:0]       cur_char_ff, cur_char_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       row_ff, row_in;
   logic             finished_ff, finished_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mte_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic [3:0]       open_next;
   logic [7:0]       open_char;
   logic [3:0]       step_idx, step_next;
   logic [7:0]       step_char;
   logic [15:0]      tick_inc;
   logic [COL_W-1:0] adv_col;
   logic [1:0]       adv_row;
   logic [CNT_W-1:0] adv_count;
   logic             adv_fin;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign open_char = mte_pkg::key_char(req_data.key, 4'd0);
   assign open_next = (mte_pkg::key_len(req_data.key) == 4'd1) ? 4'd0 : 4'd1;
   assign step_idx  = (tap_idx_ff >= mte_pkg::key_len(req_data.key)) ? 4'd0 : tap_idx_ff;
   assign step_char = mte_pkg::key_char(req_data.key, step_idx);
   assign step_next = (step_idx + 4'd1 == mte_pkg::key_len(req_data.key)) ?
                      4'd0 : step_idx + 4'd1;
   assign tick_inc  = (tick_cnt_ff < mte_pkg::TICK_MAX) ? tick_cnt_ff + 16'd1 : tick_cnt_ff;

   always_comb begin
      adv_col = col_ff + COL_W'(1);
      adv_row = row_ff;
      if (col_ff == COL_W'(ROW_WIDTH)) begin
         adv_col = COL_W'(1);
         if (row_ff < mte_pkg::ROW_LAST) begin
            adv_row = row_ff + 2'd1;
         end
      end
      adv_count = count_ff;
      adv_fin   = 1'b0;
      if (cur_char_ff == mte_pkg::CHAR_AT) begin
         adv_fin = 1'b1;
      end else begin
         adv_count = count_ff + CNT_W'(1);
         adv_fin   = (count_ff == CNT_W'(MAX_CHARS - 1));
      end
   end

   always_comb begin
      cell_open_in = cell_open_ff;
      prev_key_in  = prev_key_ff;
      tap_idx_in   = tap_idx_ff;
      tick_cnt_in  = tick_cnt_ff;
      timed_out_in = timed_out_ff;
      cur_char_in  = cur_char_ff;
      count_in     = count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      finished_in  = finished_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in.kind      = mte_pkg::KIND_SHOW;
      rsp_data_in.character = open_char;
      rsp_data_in.column    = 5'(col_ff);
      rsp_data_in.row       = row_ff;
      rsp_data_in.replace   = 1'b0;
      rsp_data_in.length    = 6'(count_ff);
      if (req_fire && !finished_ff) begin
         if (req_data.func == mte_pkg::FUNC_TICK) begin
            if (cell_open_ff && !timed_out_ff) begin
               tick_cnt_in  = tick_inc;
               timed_out_in = (tick_inc >= timeout_ff);
            end
         end else if (req_data.key <= mte_pkg::KEY_AT) begin
            rsp_valid_in = 1'b1;
            tick_cnt_in  = '0;
            timed_out_in = 1'b0;
            if (!cell_open_ff) begin
               cell_open_in = 1'b1;
               prev_key_in  = req_data.key;
               tap_idx_in   = open_next;
               cur_char_in  = open_char;
            end else if (!timed_out_ff && req_data.key == prev_key_ff) begin
               tap_idx_in  = step_next;
               cur_char_in = step_char;
               rsp_data_in.character = step_char;
               rsp_data_in.replace   = 1'b1;
            end else begin
               col_in   = adv_col;
               row_in   = adv_row;
               count_in = adv_count;
               rsp_data_in.length = 6'(adv_count);
               if (adv_fin) begin
                  finished_in  = 1'b1;
                  cell_open_in = 1'b0;
                  cur_char_in  = mte_pkg::CHAR_SPACE;
                  tick_cnt_in  = tick_cnt_ff;
                  timed_out_in = timed_out_ff;
                  rsp_data_in.kind      = mte_pkg::KIND_DONE;
                  rsp_data_in.character = cur_char_ff;
               end else begin
                  cell_open_in = 1'b1;
                  prev_key_in  = req_data.key;
                  tap_idx_in   = open_next;
                  cur_char_in  = open_char;
                  rsp_data_in.column = 5'(adv_col);
                  rsp_data_in.row    = adv_row;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= mte_pkg::TIMEOUT_RESET;
         cell_open_ff <= 1'b0;
         prev_key_ff  <= '0;
         tap_idx_ff   <= '0;
         tick_cnt_ff  <= '0;
         timed_out_ff <= 1'b0;
         cur_char_ff  <= mte_pkg::CHAR_SPACE;
         count_ff     <= '0;
         col_ff       <= COL_W'(1);
         row_ff       <= 2'd1;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         cell_open_ff <= cell_open_in;
         prev_key_ff  <= prev_key_in;
         tap_idx_ff   <= tap_idx_in;
         tick_cnt_ff  <= tick_cnt_in;
         timed_out_ff <= timed_out_in;
         cur_char_ff  <= cur_char_in;
         count_ff     <= count_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         finished_ff  <= finished_in;
         if (req_ready) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_done_closes_cell: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !cell_open_ff)
      else $error("cell open after message complete");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      col_ff >= COL_W'(1) && col_ff <= COL_W'(ROW_WIDTH) && row_ff != 2'd0)
      else $error("cursor out of range");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CHARS))
      else $error("committed count beyond limit");

   a_done_item_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == mte_pkg::KIND_DONE |->
         finished_ff && !rsp_data_ff.replace)
      else $error("completion item without finished state");

endmodule
